>>> rtl/brpt_pkg.sv
// ----------------------------------------------------------------------------
// Box region protection table: shared package
// Types, codes and conversion helpers used by the cells, the channel
// interfaces and the top level.
// ----------------------------------------------------------------------------
package brpt_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FLAG_BITS  = 4;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_ID     = 3'd1;
  localparam logic [2:0] ERR_BAD_BOUNDS = 3'd2;
  localparam logic [2:0] ERR_NO_FLAGS   = 3'd3;
  localparam logic [2:0] ERR_DUPLICATE  = 3'd4;
  localparam logic [2:0] ERR_FULL       = 3'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [FLAG_BITS-1:0]         flags_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [63:0]        box_id;
    logic signed [31:0] lower_x;
    logic signed [31:0] lower_y;
    logic signed [31:0] lower_z;
    logic signed [31:0] upper_x;
    logic signed [31:0] upper_y;
    logic signed [31:0] upper_z;
    logic [3:0]         box_flags;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [2:0]         error_code;
    logic [4:0]         entry_count;
    logic [3:0]         flags_out;
    logic signed [31:0] found_lower_x;
    logic signed [31:0] found_lower_y;
    logic signed [31:0] found_lower_z;
    logic signed [31:0] found_upper_x;
    logic signed [31:0] found_upper_y;
    logic signed [31:0] found_upper_z;
  } rsp_t;

  typedef struct packed {
    logic [63:0]  id;
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    flags_t       flags;
  } entry_t;

  typedef struct packed {
    logic [63:0]  id;
    coord_t [2:0] pos;
  } probe_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic   hit;
    flags_t cover_flags;
  } cell_stat_t;

  function automatic coord_t to_coord(logic [31:0] raw);
    logic [63:0] wide;
    wide = {32'b0, raw};
    return coord_t'(wide[COORD_BITS-1:0]);
  endfunction

  function automatic logic [31:0] from_coord(coord_t c);
    logic signed [63:0] wide;
    wide = 64'(c);
    return wide[31:0];
  endfunction

  function automatic flags_t to_flags(logic [3:0] raw);
    logic [31:0] wide;
    wide = {28'b0, raw};
    return wide[FLAG_BITS-1:0];
  endfunction

  function automatic logic [3:0] from_flags(flags_t f);
    logic [31:0] wide;
    wide = 32'(f);
    return wide[3:0];
  endfunction

endpackage

>>> rtl/brpt_if.sv
// ----------------------------------------------------------------------------
// Box region protection table: channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface brpt_in_if;
  logic          valid;
  logic          ready;
  brpt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brpt_out_if;
  logic          valid;
  logic          ready;
  brpt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/box_region_protection_table.sv
// ----------------------------------------------------------------------------
// Box region protection table
// Row of entry cells holding up to CAPACITY boxes; insert, remove with
// compaction, cell query, lookup by id and clear.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in_i    | in  | valid/ready       | operation, id, box corners, flags, cell
//  out_o   | out | valid/ready       | success, error, count, flags, corners
//
//  A match phase registers every cell's id and box match; a commit phase
//  commits the update and loads the result register.
//  A result stalled on out_o holds the commit cycle; no new transfer is taken.
//  Reset clears the entry count; box storage is left as it is.
// ----------------------------------------------------------------------------
module box_region_protection_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brpt_in_if.sink     in_i,
  brpt_out_if.source  out_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhMatch  = 2'd1;
  localparam logic [1:0] PhCommit = 2'd2;

  logic [1:0]            phase_q, phase_d;
  brpt_pkg::req_t        req_q;
  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  brpt_pkg::rsp_t        rsp_q, rsp_d;

  brpt_pkg::probe_t      probe;
  brpt_pkg::entry_t      new_entry;
  brpt_pkg::entry_t      chain [CAPACITY:0];
  brpt_pkg::cell_ctrl_t  ctrl  [CAPACITY];
  brpt_pkg::cell_stat_t  stat  [CAPACITY];
  logic [CAPACITY-1:0]   active;

  logic                  any_hit;
  logic [IdxW-1:0]       hit_idx;
  brpt_pkg::flags_t      cover_or;
  brpt_pkg::entry_t      found;
  logic                  space, commit, in_fire;
  logic                  bad_bounds, full;
  logic [2:0]            ins_err;
  logic [31:0]           cnt_wide;

  // probe and candidate entry from the held request
  always_comb begin
    probe.id       = req_q.box_id;
    probe.pos[0]   = brpt_pkg::to_coord(req_q.cell_x);
    probe.pos[1]   = brpt_pkg::to_coord(req_q.cell_y);
    probe.pos[2]   = brpt_pkg::to_coord(req_q.cell_z);
    new_entry.id   = req_q.box_id;
    new_entry.lo[0] = brpt_pkg::to_coord(req_q.lower_x);
    new_entry.lo[1] = brpt_pkg::to_coord(req_q.lower_y);
    new_entry.lo[2] = brpt_pkg::to_coord(req_q.lower_z);
    new_entry.hi[0] = brpt_pkg::to_coord(req_q.upper_x);
    new_entry.hi[1] = brpt_pkg::to_coord(req_q.upper_y);
    new_entry.hi[2] = brpt_pkg::to_coord(req_q.upper_z);
    new_entry.flags = brpt_pkg::to_flags(req_q.box_flags);
  end

  assign chain[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign active[g] = CntW'(g) < count_q;

    brpt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active[g]),
      .probe_i  (probe),
      .wr_i     (new_entry),
      .next_i   (chain[g+1]),
      .ctrl_i   (ctrl[g]),
      .entry_o  (chain[g]),
      .stat_o   (stat[g])
    );
  end

  // combine the registered per-cell matches
  always_comb begin
    any_hit  = 1'b0;
    hit_idx  = '0;
    cover_or = '0;
    found    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (stat[i].hit) begin
        any_hit = 1'b1;
        hit_idx = hit_idx | IdxW'(i);
        found   = found | chain[i];
      end
      cover_or = cover_or | stat[i].cover_flags;
    end
  end

  assign space   = !out_valid_q || out_o.ready;
  assign commit  = (phase_q == PhCommit) && space;
  assign in_i.ready = (phase_q == PhIdle) || commit;
  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    bad_bounds = ($signed(new_entry.lo[0]) > $signed(new_entry.hi[0])) ||
                 ($signed(new_entry.lo[1]) > $signed(new_entry.hi[1])) ||
                 ($signed(new_entry.lo[2]) > $signed(new_entry.hi[2]));
    full = count_q >= CntW'(CAPACITY);
    if (req_q.box_id == 64'd0) begin
      ins_err = brpt_pkg::ERR_BAD_ID;
    end else if (bad_bounds) begin
      ins_err = brpt_pkg::ERR_BAD_BOUNDS;
    end else if (new_entry.flags == '0) begin
      ins_err = brpt_pkg::ERR_NO_FLAGS;
    end else if (any_hit) begin
      ins_err = brpt_pkg::ERR_DUPLICATE;
    end else if (full) begin
      ins_err = brpt_pkg::ERR_FULL;
    end else begin
      ins_err = brpt_pkg::ERR_NONE;
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].load  = commit && (req_q.operation == brpt_pkg::OP_INSERT) &&
                      (ins_err == brpt_pkg::ERR_NONE) && (CntW'(i) == count_q);
      ctrl[i].shift = commit && (req_q.operation == brpt_pkg::OP_REMOVE) &&
                      any_hit && (IdxW'(i) >= hit_idx);
    end
  end

  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    case (req_q.operation)
      brpt_pkg::OP_INSERT: begin
        rsp_d.error_code = ins_err;
        if (ins_err == brpt_pkg::ERR_NONE) begin
          rsp_d.success = 1'b1;
          count_d       = count_q + CntW'(1);
        end
      end
      brpt_pkg::OP_REMOVE: begin
        if (any_hit) begin
          rsp_d.success = 1'b1;
          count_d       = count_q - CntW'(1);
        end
      end
      brpt_pkg::OP_QUERY: begin
        rsp_d.success   = 1'b1;
        rsp_d.flags_out = brpt_pkg::from_flags(cover_or);
      end
      brpt_pkg::OP_LOOKUP: begin
        if (any_hit) begin
          rsp_d.success       = 1'b1;
          rsp_d.flags_out     = brpt_pkg::from_flags(found.flags);
          rsp_d.found_lower_x = brpt_pkg::from_coord(found.lo[0]);
          rsp_d.found_lower_y = brpt_pkg::from_coord(found.lo[1]);
          rsp_d.found_lower_z = brpt_pkg::from_coord(found.lo[2]);
          rsp_d.found_upper_x = brpt_pkg::from_coord(found.hi[0]);
          rsp_d.found_upper_y = brpt_pkg::from_coord(found.hi[1]);
          rsp_d.found_upper_z = brpt_pkg::from_coord(found.hi[2]);
        end
      end
      brpt_pkg::OP_CLEAR: begin
        rsp_d.success = 1'b1;
        count_d       = '0;
      end
      default: begin
      end
    endcase
    cnt_wide          = 32'(count_d);
    rsp_d.entry_count = cnt_wide[4:0];
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhIdle: begin
        if (in_fire) begin
          phase_d = PhMatch;
        end
      end
      PhMatch: begin
        phase_d = PhCommit;
      end
      PhCommit: begin
        if (commit) begin
          phase_d = in_fire ? PhMatch : PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_i.data;
    end
    if (commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = rsp_q;

endmodule

>>> rtl/brpt_cell.sv
// ----------------------------------------------------------------------------
// Box region protection table: entry cell
// Holds one box, matches it against the probe id and position, and loads a
// new box or takes its upper neighbour's box during compaction.
// ----------------------------------------------------------------------------
module brpt_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    active_i,
  input  brpt_pkg::probe_t        probe_i,
  input  brpt_pkg::entry_t        wr_i,
  input  brpt_pkg::entry_t        next_i,
  input  brpt_pkg::cell_ctrl_t    ctrl_i,
  output brpt_pkg::entry_t        entry_o,
  output brpt_pkg::cell_stat_t    stat_o
);

  brpt_pkg::entry_t     entry_q;
  brpt_pkg::cell_stat_t stat_q, stat_d;
  logic                 covers;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= wr_i;
    end else if (ctrl_i.shift) begin
      entry_q <= next_i;
    end
  end

  always_comb begin
    covers = active_i &&
             $signed(probe_i.pos[0]) >= $signed(entry_q.lo[0]) &&
             $signed(probe_i.pos[0]) <= $signed(entry_q.hi[0]) &&
             $signed(probe_i.pos[1]) >= $signed(entry_q.lo[1]) &&
             $signed(probe_i.pos[1]) <= $signed(entry_q.hi[1]) &&
             $signed(probe_i.pos[2]) >= $signed(entry_q.lo[2]) &&
             $signed(probe_i.pos[2]) <= $signed(entry_q.hi[2]);
    stat_d.hit         = active_i && (entry_q.id == probe_i.id);
    stat_d.cover_flags = covers ? entry_q.flags : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
    end else begin
      stat_q <= stat_d;
    end
  end

  assign entry_o = entry_q;
  assign stat_o  = stat_q;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Box region protection table: testbench
// Drives insert, remove, cell query, lookup, clear and reserved requests over
// the input channel, a directed list and then random bursts, and keeps a
// shadow copy of the box table to work out every reply. Replies are compared
// field by field in order. The receiver stalls on its own pattern, with long
// hold-offs that fill the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_LAST = 3'd7;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] C_MAX = 32'h7fff_ffff;
  localparam logic [63:0] ID_ALL_ONES = '1;
  localparam logic [63:0] ID_HIGH = 64'h8000_0000_0000_0002;

  class box_table_shadow;
    logic [63:0]        slot_id[TABLE_DEPTH];
    logic signed [31:0] slot_lo[TABLE_DEPTH][3];
    logic signed [31:0] slot_hi[TABLE_DEPTH][3];
    logic [3:0]         slot_flags[TABLE_DEPTH];
    int                 held;
    brpt_pkg::rsp_t     expected_replies[$];
    int                 mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function int find_slot(logic [63:0] id);
      for (int i = 0; i < held; i++) begin
        if (slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_request(brpt_pkg::req_t r);
      brpt_pkg::rsp_t     e;
      logic signed [31:0] lo[3];
      logic signed [31:0] hi[3];
      logic signed [31:0] pos[3];
      logic [3:0]         acc;
      logic               hit;
      int                 idx;
      int                 i;
      int                 a;
      e = '0;
      lo[0] = r.lower_x;
      lo[1] = r.lower_y;
      lo[2] = r.lower_z;
      hi[0] = r.upper_x;
      hi[1] = r.upper_y;
      hi[2] = r.upper_z;
      pos[0] = r.cell_x;
      pos[1] = r.cell_y;
      pos[2] = r.cell_z;
      case (r.operation)
        brpt_pkg::OP_INSERT: begin
          if (r.box_id == '0) begin
            e.error_code = brpt_pkg::ERR_BAD_ID;
          end else if (lo[0] > hi[0] || lo[1] > hi[1] || lo[2] > hi[2]) begin
            e.error_code = brpt_pkg::ERR_BAD_BOUNDS;
          end else if (r.box_flags == '0) begin
            e.error_code = brpt_pkg::ERR_NO_FLAGS;
          end else if (find_slot(r.box_id) >= 0) begin
            e.error_code = brpt_pkg::ERR_DUPLICATE;
          end else if (held >= TABLE_DEPTH) begin
            e.error_code = brpt_pkg::ERR_FULL;
          end else begin
            slot_id[held] = r.box_id;
            slot_flags[held] = r.box_flags;
            for (a = 0; a < 3; a++) begin
              slot_lo[held][a] = lo[a];
              slot_hi[held][a] = hi[a];
            end
            held++;
            e.success = 1'b1;
          end
        end
        brpt_pkg::OP_REMOVE: begin
          idx = find_slot(r.box_id);
          if (idx >= 0) begin
            for (i = idx + 1; i < held; i++) begin
              slot_id[i-1] = slot_id[i];
              slot_flags[i-1] = slot_flags[i];
              slot_lo[i-1] = slot_lo[i];
              slot_hi[i-1] = slot_hi[i];
            end
            held--;
            e.success = 1'b1;
          end
        end
        brpt_pkg::OP_QUERY: begin
          acc = '0;
          for (i = 0; i < held; i++) begin
            hit = 1'b1;
            for (a = 0; a < 3; a++) begin
              if (pos[a] < slot_lo[i][a] || pos[a] > slot_hi[i][a]) hit = 1'b0;
            end
            if (hit) acc |= slot_flags[i];
          end
          e.flags_out = acc;
          e.success = 1'b1;
        end
        brpt_pkg::OP_LOOKUP: begin
          idx = find_slot(r.box_id);
          if (idx >= 0) begin
            e.flags_out = slot_flags[idx];
            e.found_lower_x = slot_lo[idx][0];
            e.found_lower_y = slot_lo[idx][1];
            e.found_lower_z = slot_lo[idx][2];
            e.found_upper_x = slot_hi[idx][0];
            e.found_upper_y = slot_hi[idx][1];
            e.found_upper_z = slot_hi[idx][2];
            e.success = 1'b1;
          end
        end
        brpt_pkg::OP_CLEAR: begin
          held = 0;
          e.success = 1'b1;
        end
        default: begin
        end
      endcase
      e.entry_count = 5'(held);
      expected_replies.push_back(e);
    endfunction

    function void check_reply(brpt_pkg::rsp_t got);
      brpt_pkg::rsp_t e;
      logic [63:0]    want[10];
      logic [63:0]    seen[10];
      string          tag[10];
      bit             bad;
      if (expected_replies.size() == 0) begin
        if (mismatches < 10) $display("unexpected reply with nothing outstanding: %h", got);
        mismatches++;
        return;
      end
      e = expected_replies.pop_front();
      tag = '{"success", "error_code", "entry_count", "flags_out", "found_lower_x",
              "found_lower_y", "found_lower_z", "found_upper_x", "found_upper_y",
              "found_upper_z"};
      want = '{64'(e.success), 64'(e.error_code), 64'(e.entry_count), 64'(e.flags_out),
               64'(e.found_lower_x), 64'(e.found_lower_y), 64'(e.found_lower_z),
               64'(e.found_upper_x), 64'(e.found_upper_y), 64'(e.found_upper_z)};
      seen = '{64'(got.success), 64'(got.error_code), 64'(got.entry_count),
               64'(got.flags_out), 64'(got.found_lower_x), 64'(got.found_lower_y),
               64'(got.found_lower_z), 64'(got.found_upper_x), 64'(got.found_upper_y),
               64'(got.found_upper_z)};
      bad = 1'b0;
      for (int f = 0; f < 10; f++) begin
        if (want[f] !== seen[f]) begin
          if (mismatches < 10) begin
            $display("reply mismatch on %s: expected %h, got %h", tag[f], want[f], seen[f]);
          end
          bad = 1'b1;
        end
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  brpt_in_if  in_if ();
  brpt_out_if out_if ();

  box_region_protection_table #(
    .CAPACITY (TABLE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  box_table_shadow shadow;
  logic [63:0]     id_pool[24];

  always #2 clk_i = ~clk_i;

  function automatic brpt_pkg::req_t noise_req();
    brpt_pkg::req_t r;
    r.operation = 3'($urandom_range(0, 7));
    r.box_id = {$urandom, $urandom};
    r.lower_x = $urandom;
    r.lower_y = $urandom;
    r.lower_z = $urandom;
    r.upper_x = $urandom;
    r.upper_y = $urandom;
    r.upper_z = $urandom;
    r.box_flags = 4'($urandom_range(0, 15));
    r.cell_x = $urandom;
    r.cell_y = $urandom;
    r.cell_z = $urandom;
    return r;
  endfunction

  function automatic brpt_pkg::req_t box_cmd(logic [2:0] op, logic [63:0] id,
                                             logic [31:0] lx, logic [31:0] ly,
                                             logic [31:0] lz, logic [31:0] ux,
                                             logic [31:0] uy, logic [31:0] uz,
                                             logic [3:0] f);
    brpt_pkg::req_t r;
    r = noise_req();
    r.operation = op;
    r.box_id = id;
    r.lower_x = lx;
    r.lower_y = ly;
    r.lower_z = lz;
    r.upper_x = ux;
    r.upper_y = uy;
    r.upper_z = uz;
    r.box_flags = f;
    return r;
  endfunction

  function automatic brpt_pkg::req_t probe_cmd(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z);
    brpt_pkg::req_t r;
    r = noise_req();
    r.operation = brpt_pkg::OP_QUERY;
    r.cell_x = x;
    r.cell_y = y;
    r.cell_z = z;
    return r;
  endfunction

  function automatic brpt_pkg::req_t id_cmd(logic [2:0] op, logic [63:0] id);
    brpt_pkg::req_t r;
    r = noise_req();
    r.operation = op;
    r.box_id = id;
    return r;
  endfunction

  // mostly small coordinates so boxes overlap and queries hit
  function automatic logic [31:0] pick_coord();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 80) return $urandom_range(0, 12) - 32'd6;
    if (w < 88) return ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
    return $urandom;
  endfunction

  function automatic void draw_span(output logic [31:0] lo, output logic [31:0] hi,
                                    input bit ordered);
    logic [31:0] a;
    logic [31:0] b;
    a = pick_coord();
    b = pick_coord();
    if (ordered && $signed(a) > $signed(b)) begin
      lo = b;
      hi = a;
    end else begin
      lo = a;
      hi = b;
    end
  endfunction

  function automatic logic [63:0] pick_id();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 5) return '0;
    if (w < 15) return {$urandom, $urandom};
    if (w < 45 && shadow.held > 0) return shadow.slot_id[$urandom_range(0, shadow.held - 1)];
    return id_pool[$urandom_range(0, 23)];
  endfunction

  function automatic brpt_pkg::req_t random_request();
    brpt_pkg::req_t r;
    int unsigned    w;
    bit             ordered;
    logic [31:0]    lo;
    logic [31:0]    hi;
    r = noise_req();
    r.box_id = pick_id();
    w = $urandom_range(0, 99);
    if (w < 36) r.operation = brpt_pkg::OP_INSERT;
    else if (w < 50) r.operation = brpt_pkg::OP_REMOVE;
    else if (w < 70) r.operation = brpt_pkg::OP_QUERY;
    else if (w < 88) r.operation = brpt_pkg::OP_LOOKUP;
    else if (w < 89) r.operation = brpt_pkg::OP_CLEAR;
    else if (w < 94) r.operation = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
    if (r.operation == brpt_pkg::OP_INSERT) begin
      ordered = ($urandom_range(0, 99) >= 8);
      draw_span(lo, hi, ordered);
      r.lower_x = lo;
      r.upper_x = hi;
      draw_span(lo, hi, ordered);
      r.lower_y = lo;
      r.upper_y = hi;
      draw_span(lo, hi, ordered);
      r.lower_z = lo;
      r.upper_z = hi;
      r.box_flags = ($urandom_range(0, 99) < 92) ? 4'($urandom_range(1, 15)) : 4'h0;
    end else if (r.operation == brpt_pkg::OP_QUERY) begin
      r.cell_x = pick_coord();
      r.cell_y = pick_coord();
      r.cell_z = pick_coord();
    end
    return r;
  endfunction

  // called just after a rising edge; returns at the edge of the transfer
  task automatic send(input brpt_pkg::req_t r);
    in_if.valid <= 1'b1;
    in_if.data <= r;
    do @(negedge clk_i); while (in_if.ready !== 1'b1);
    @(posedge clk_i);
    shadow.note_request(r);
  endtask

  task automatic pause(input int unsigned cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      shadow.check_reply(out_if.data);
    end
  end

  initial begin : receiver
    int unsigned cycle;
    int unsigned hold_left;
    int unsigned mode;
    cycle = 0;
    hold_left = 0;
    mode = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle % 64 == 0) mode = $urandom_range(0, 3);
      // long hold-off so the block fills and back-pressures its input
      if (hold_left == 0 && cycle % 3000 == 1500) hold_left = $urandom_range(150, 300);
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) != 0);
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= cycle[0];
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    brpt_pkg::req_t plan[$];
    brpt_pkg::req_t r;
    int unsigned    accepted;
    int unsigned    burst;
    bit             paused;
    shadow = new();
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    for (int k = 0; k < 24; k++) begin
      id_pool[k] = (k < 12) ? 64'(k + 1) : ({$urandom, $urandom} | 64'd1);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(probe_cmd('0, '0, '0));
    plan.push_back(id_cmd(brpt_pkg::OP_LOOKUP, 64'd5));
    plan.push_back(id_cmd(brpt_pkg::OP_REMOVE, 64'd5));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, '0, -32'sd1, -32'sd1, -32'sd1,
                           1, 1, 1, 4'h1));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, 64'd7, 2, 0, 0, 1, 0, 0, 4'h1));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, 64'd7, 0, C_MAX, 0, 0, C_MIN, 0, 4'h1));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, 64'd7, 0, 0, 1, 0, 0, 0, 4'h1));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, 64'd7, 0, 0, 0, 0, 0, 0, 4'h0));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, ID_ALL_ONES, C_MIN, C_MIN, C_MIN,
                           C_MAX, C_MAX, C_MAX, 4'h8));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, 64'd1, -32'sd3, -32'sd3, -32'sd3,
                           3, 3, 3, 4'h1));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, 64'd1, 0, 0, 0, 0, 0, 0, 4'h2));
    plan.push_back(box_cmd(brpt_pkg::OP_INSERT, ID_HIGH, C_MAX, C_MIN, 0,
                           C_MAX, C_MIN, 0, 4'h2));
    plan.push_back(probe_cmd(3, -32'sd3, 3));
    plan.push_back(probe_cmd(4, 0, 0));
    plan.push_back(probe_cmd(C_MAX, C_MIN, 0));
    plan.push_back(probe_cmd(C_MIN, C_MIN, C_MIN));
    plan.push_back(id_cmd(brpt_pkg::OP_LOOKUP, ID_ALL_ONES));
    plan.push_back(id_cmd(brpt_pkg::OP_LOOKUP, ID_HIGH));
    plan.push_back(id_cmd(brpt_pkg::OP_REMOVE, 64'd1));
    plan.push_back(id_cmd(brpt_pkg::OP_LOOKUP, ID_HIGH));
    plan.push_back(id_cmd(brpt_pkg::OP_REMOVE, '0));
    plan.push_back(id_cmd(OP_RESERVED_FIRST, ID_HIGH));
    plan.push_back(id_cmd(OP_RESERVED_LAST, ID_ALL_ONES));
    plan.push_back(id_cmd(brpt_pkg::OP_CLEAR, '0));
    plan.push_back(id_cmd(brpt_pkg::OP_LOOKUP, ID_ALL_ONES));
    foreach (plan[k]) send(plan[k]);
    drain();

    accepted = 0;
    paused = 1'b0;
    while (accepted < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        r = random_request();
        send(r);
        if (r.operation <= brpt_pkg::OP_CLEAR) accepted++;
      end
      if (!paused && accepted >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end else if ($urandom_range(0, 9) >= 4) begin
        pause($urandom_range(1, 10));
      end
    end
    drain();
    repeat (10) @(posedge clk_i);

    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
